// ===== src/prs_pkg.sv =====
// shared types and constants for the polyphase resampler
package prs_pkg;

    localparam int SAMPLE_W = 16;
    localparam int COEF_W   = 18;
    localparam int PROD_W   = SAMPLE_W + COEF_W;
    localparam int SHIFT_W  = 5;
    localparam int IDX_W    = 10;
    localparam logic [SHIFT_W-1:0] SHIFT_RESET = 5'd17;

    typedef enum logic {
        OP_LOAD   = 1'b0,
        OP_SAMPLE = 1'b1
    } opcode_t;

    // control for the coefficient read that feeds the cell row
    typedef struct packed {
        logic valid;
        logic last;
    } ctl_t;

endpackage

// ===== src/prs_ram.sv =====
// generic single port write, one registered read port ram
module prs_ram #(
    parameter int WIDTH = 18,
    parameter int DEPTH = 560
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== src/prs_cell.sv =====
// one multiply-accumulate cell of the resampler chain, real and imaginary
module prs_cell #(
    parameter int ACC_W = 40
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic signed [prs_pkg::SAMPLE_W-1:0] tap_re,
    input  logic signed [prs_pkg::SAMPLE_W-1:0] tap_im,
    input  logic signed [prs_pkg::COEF_W-1:0]   coef,
    input  logic                                clear,
    input  logic                                en,
    input  logic signed [ACC_W-1:0]             acc_re_in,
    input  logic signed [ACC_W-1:0]             acc_im_in,
    output logic signed [ACC_W-1:0]             acc_re_out,
    output logic signed [ACC_W-1:0]             acc_im_out
);

    logic signed [prs_pkg::PROD_W-1:0] prod_re;
    logic signed [prs_pkg::PROD_W-1:0] prod_im;
    logic signed [ACC_W-1:0]           acc_re_reg;
    logic signed [ACC_W-1:0]           acc_im_reg;
    logic signed [ACC_W-1:0]           base_re;
    logic signed [ACC_W-1:0]           base_im;

    assign prod_re = tap_re * coef;
    assign prod_im = tap_im * coef;
    assign base_re = clear ? '0 : acc_re_in;
    assign base_im = clear ? '0 : acc_im_in;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_re_reg <= '0;
            acc_im_reg <= '0;
        end else if (en) begin
            acc_re_reg <= base_re + ACC_W'(prod_re);
            acc_im_reg <= base_im + ACC_W'(prod_im);
        end
    end

    assign acc_re_out = acc_re_reg;
    assign acc_im_out = acc_im_reg;

endmodule

// ===== src/polyphase_resampler_35_39.sv =====
// polyphase resampler: coefficient load and sample words in, at most one output per sample
// a sample that completes an output reads its coefficient row one tap per cycle
// through the cell chain, then a done flag and the output register set output valid
// input held off until that output is sent
// other words are taken one per cycle while no output is in progress
// sync reset clears delay line, phase and output valid, sets inputs needed to 2 and shift to 17
module polyphase_resampler_35_39 #(
    parameter int TAPS_PER_PHASE = 16,
    parameter int UP_PHASES      = 35,
    parameter int DOWN_STEP      = 39
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic                                s_opcode,
    input  logic [prs_pkg::IDX_W-1:0]           s_coef_index,
    input  logic signed [prs_pkg::COEF_W-1:0]   s_coef_value,
    input  logic signed [prs_pkg::SAMPLE_W-1:0] s_sample_re,
    input  logic signed [prs_pkg::SAMPLE_W-1:0] s_sample_im,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [prs_pkg::SHIFT_W-1:0]         cfg_data,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic signed [prs_pkg::SAMPLE_W-1:0] m_out_re,
    output logic signed [prs_pkg::SAMPLE_W-1:0] m_out_im,
    output logic                                m_saturated
);

    localparam int DEPTH   = UP_PHASES * TAPS_PER_PHASE;
    localparam int ADDR_W  = $clog2(DEPTH);
    localparam int TAP_W   = $clog2(TAPS_PER_PHASE);
    localparam int PH_W    = $clog2(UP_PHASES);
    localparam int WRAP_W  = $clog2(DOWN_STEP / UP_PHASES + 2);
    localparam int ACC_W   = prs_pkg::PROD_W + TAP_W + 1;
    localparam int SUM_W   = $clog2(UP_PHASES + DOWN_STEP + 1);
    localparam int WRAPS   = (UP_PHASES - 1 + DOWN_STEP) / UP_PHASES;
    localparam int SW      = prs_pkg::SAMPLE_W;

    // delay line
    logic signed [SW-1:0] dl_re_reg [TAPS_PER_PHASE];
    logic signed [SW-1:0] dl_im_reg [TAPS_PER_PHASE];

    logic [PH_W-1:0]   phase_reg, phase_next;
    logic [WRAP_W-1:0] need_reg, need_next;
    logic [prs_pkg::SHIFT_W-1:0] shift_reg;
    logic              busy_reg, busy_next;
    logic [TAP_W:0]    cnt_reg, cnt_next;
    logic [ADDR_W-1:0] row_reg, row_next;
    prs_pkg::ctl_t     rd_reg;
    logic [TAP_W-1:0]  rd_tap_reg;
    logic              done_reg;

    logic in_acc, is_load, is_sample, fire;
    logic [ADDR_W-1:0] raddr;
    logic signed [prs_pkg::COEF_W-1:0] coef;

    assign s_ready   = !busy_reg && !rd_reg.valid && !m_valid && !done_reg;
    assign cfg_ready = 1'b1;
    assign in_acc    = s_valid && s_ready;
    assign is_load   = in_acc && (s_opcode == prs_pkg::OP_LOAD);
    assign is_sample = in_acc && (s_opcode == prs_pkg::OP_SAMPLE);
    assign fire      = is_sample && (need_reg <= WRAP_W'(1));

    prs_ram #(.WIDTH(prs_pkg::COEF_W), .DEPTH(DEPTH)) u_coef (
        .aclk (aclk),
        .we   (is_load && (32'(s_coef_index) < DEPTH)),
        .waddr(ADDR_W'(s_coef_index)),
        .wdata(s_coef_value),
        .raddr(raddr),
        .rdata(coef)
    );

    assign raddr = row_reg + ADDR_W'(cnt_reg[TAP_W-1:0]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < TAPS_PER_PHASE; i++) begin
                dl_re_reg[i] <= '0;
                dl_im_reg[i] <= '0;
            end
        end else if (is_sample) begin
            dl_re_reg[0] <= s_sample_re;
            dl_im_reg[0] <= s_sample_im;
            for (int i = 1; i < TAPS_PER_PHASE; i++) begin
                dl_re_reg[i] <= dl_re_reg[i-1];
                dl_im_reg[i] <= dl_im_reg[i-1];
            end
        end
    end

    // phase step and sequencer
    always_comb begin
        logic [SUM_W-1:0] sum;
        sum        = SUM_W'(phase_reg) + SUM_W'(DOWN_STEP);
        phase_next = phase_reg;
        need_next  = need_reg;
        busy_next  = busy_reg;
        cnt_next   = cnt_reg;
        row_next   = row_reg;
        if (is_sample) begin
            if (!fire) begin
                need_next = need_reg - WRAP_W'(1);
            end else begin
                busy_next = 1'b1;
                cnt_next  = '0;
                row_next  = ADDR_W'(32'(phase_reg) * TAPS_PER_PHASE);
                // repeated subtraction, wraps is a small constant bound
                need_next = '0;
                for (int k = 0; k < WRAPS; k++) begin
                    if (sum >= SUM_W'(UP_PHASES)) begin
                        sum       = sum - SUM_W'(UP_PHASES);
                        need_next = need_next + WRAP_W'(1);
                    end
                end
                if (need_next == '0) begin
                    need_next = WRAP_W'(1);
                end
                phase_next = PH_W'(sum);
            end
        end else if (busy_reg) begin
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == (TAP_W+1)'(TAPS_PER_PHASE - 1)) begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= '0;
            need_reg  <= WRAP_W'(2);
            busy_reg  <= 1'b0;
            cnt_reg   <= '0;
            rd_reg    <= '0;
            shift_reg <= prs_pkg::SHIFT_RESET;
        end else begin
            phase_reg <= phase_next;
            need_reg  <= need_next;
            busy_reg  <= busy_next;
            cnt_reg   <= cnt_next;
            rd_reg.valid <= busy_reg;
            rd_reg.last  <= busy_reg && (cnt_reg == (TAP_W+1)'(TAPS_PER_PHASE - 1));
            if (cfg_valid && cfg_ready) begin
                shift_reg <= cfg_data;
            end
        end
        row_reg    <= row_next;
        rd_tap_reg <= cnt_reg[TAP_W-1:0];
    end

    // cell chain: cell i adds tap i when its coefficient arrives
    logic signed [ACC_W-1:0] ch_re [TAPS_PER_PHASE+1];
    logic signed [ACC_W-1:0] ch_im [TAPS_PER_PHASE+1];
    assign ch_re[0] = '0;
    assign ch_im[0] = '0;

    for (genvar g = 0; g < TAPS_PER_PHASE; g++) begin : g_cell
        prs_cell #(.ACC_W(ACC_W)) u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .tap_re    (dl_re_reg[g]),
            .tap_im    (dl_im_reg[g]),
            .coef      (coef),
            .clear     (g == 0),
            .en        (rd_reg.valid && (rd_tap_reg == TAP_W'(g))),
            .acc_re_in (ch_re[g]),
            .acc_im_in (ch_im[g]),
            .acc_re_out(ch_re[g+1]),
            .acc_im_out(ch_im[g+1])
        );
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            done_reg <= 1'b0;
        end else begin
            done_reg <= rd_reg.valid && rd_reg.last;
        end
    end

    // round and saturate
    logic signed [ACC_W:0] rnd_re, rnd_im, sh_re, sh_im;
    logic clip_re, clip_im;
    logic signed [SW-1:0] sat_re, sat_im;
    localparam logic signed [ACC_W:0] MAXV = (ACC_W+1)'(32767);
    localparam logic signed [ACC_W:0] MINV = -(ACC_W+1)'(32768);

    always_comb begin
        rnd_re = (ACC_W+1)'(ch_re[TAPS_PER_PHASE]);
        rnd_im = (ACC_W+1)'(ch_im[TAPS_PER_PHASE]);
        if (shift_reg != '0) begin
            rnd_re = rnd_re + ((ACC_W+1)'(1) <<< (shift_reg - 1'b1));
            rnd_im = rnd_im + ((ACC_W+1)'(1) <<< (shift_reg - 1'b1));
        end
        sh_re   = rnd_re >>> shift_reg;
        sh_im   = rnd_im >>> shift_reg;
        clip_re = (sh_re > MAXV) || (sh_re < MINV);
        clip_im = (sh_im > MAXV) || (sh_im < MINV);
        sat_re  = (sh_re > MAXV) ? SW'(32767) : (sh_re < MINV) ? SW'(-32768) : SW'(sh_re);
        sat_im  = (sh_im > MAXV) ? SW'(32767) : (sh_im < MINV) ? SW'(-32768) : SW'(sh_im);
    end

    logic m_valid_reg;
    logic signed [SW-1:0] m_re_reg, m_im_reg;
    logic m_sat_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (done_reg) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
        if (done_reg) begin
            m_re_reg  <= sat_re;
            m_im_reg  <= sat_im;
            m_sat_reg <= clip_re || clip_im;
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_out_re    = m_re_reg;
    assign m_out_im    = m_im_reg;
    assign m_saturated = m_sat_reg;

endmodule
